// ===== hdl/irral_pkg.sv =====
// Shared types and constants for the IR range averaging and linearization block.
// Used by every module under hdl; no dependencies of its own.
`default_nettype none

package irral_pkg;

    localparam int DEF_CHANNELS = 3;
    localparam int DEF_SAMPLES  = 4;

    localparam int SAMPLE_W   = 12;
    localparam int DIST_W     = 16;
    localparam int NUMER_W    = 16;
    localparam int OFFSET_W   = 8;
    localparam int AVG_W      = 9;
    localparam int DEN_W      = 10;
    localparam int CH_OUT_W   = 2;
    localparam int CH_IDX_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = 4;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_CAP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_NUMERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_OFFSET    = 2'd2;

    localparam logic [DIST_W-1:0]   RST_DISTANCE_CAP    = 16'd65535;
    localparam logic [NUMER_W-1:0]  RST_SCALE_NUMERATOR = 16'd2914;
    localparam logic [OFFSET_W-1:0] RST_SCALE_OFFSET    = 8'd5;

    typedef struct packed {
        logic [AVG_W-1:0]    avg;
        logic [CH_IDX_W-1:0] ch;
        logic                last;
    } irral_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } irral_qstat_t;

    typedef enum logic {
        FR_ACCEPT,
        FR_DRAIN
    } irral_fr_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_UPD,
        BK_OUT
    } irral_bk_state_t;

endpackage

`default_nettype wire

// ===== hdl/irral_front.sv =====
// Front end: accepts samples, sums them per channel and hands averages to the queue.
// Depends on irral_pkg.
`default_nettype none

module irral_front #(
    parameter int CHANNELS = irral_pkg::DEF_CHANNELS,
    parameter int SAMPLES  = irral_pkg::DEF_SAMPLES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [irral_pkg::SAMPLE_W-1:0] s_sample,
    input  wire irral_pkg::irral_qstat_t       q_stat,
    output logic                               push,
    output irral_pkg::irral_job_t              push_job
);
    import irral_pkg::*;

    localparam int BUF_LEN   = CHANNELS * SAMPLES;
    localparam int POS_W     = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W     = SAMPLE_W + $clog2(SAMPLES);
    localparam int AVG_SHIFT = $clog2(SAMPLES) + 3;

    irral_fr_state_t state_reg, state_next;

    logic [POS_W-1:0] pos_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [CH_W-1:0]  drain_reg;
    logic [SUM_W-1:0] sum_reg [CHANNELS];

    logic             accept;
    logic             buf_last;
    logic             drain_last;
    logic [SUM_W-1:0] avg_full;

    assign accept     = s_valid && s_ready;
    assign buf_last   = (pos_reg == POS_W'(BUF_LEN - 1));
    assign drain_last = (drain_reg == CH_W'(CHANNELS - 1));
    assign avg_full   = sum_reg[drain_reg] >> AVG_SHIFT;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_ACCEPT: begin
                if (accept && buf_last) begin
                    state_next = FR_DRAIN;
                end
            end
            FR_DRAIN: begin
                if (!q_stat.full && drain_last) begin
                    state_next = FR_ACCEPT;
                end
            end
            default: state_next = FR_ACCEPT;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        push    = 1'b0;
        unique case (state_reg)
            FR_ACCEPT: s_ready = 1'b1;
            FR_DRAIN:  push    = !q_stat.full;
            default: begin
                s_ready = 1'b0;
                push    = 1'b0;
            end
        endcase
    end

    assign push_job.avg  = avg_full[AVG_W-1:0];
    assign push_job.ch   = CH_IDX_W'(drain_reg);
    assign push_job.last = drain_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_ACCEPT;
            pos_reg   <= '0;
            ch_reg    <= '0;
            drain_reg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (accept) begin
                sum_reg[ch_reg] <= sum_reg[ch_reg] + SUM_W'(s_sample);
                if (buf_last) begin
                    pos_reg   <= '0;
                    ch_reg    <= '0;
                    drain_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                    if (ch_reg == CH_W'(CHANNELS - 1)) begin
                        ch_reg <= '0;
                    end else begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
            end
            if (push) begin
                sum_reg[drain_reg] <= '0;
                drain_reg          <= drain_last ? '0 : drain_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/irral_queue.sv =====
// Small job queue between front end and back end.
// Depends on irral_pkg.
`default_nettype none

module irral_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire irral_pkg::irral_job_t push_job,
    input  wire logic                  pop,
    output irral_pkg::irral_job_t      head_job,
    output irral_pkg::irral_qstat_t    q_stat
);
    import irral_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    irral_job_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_job     = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/irral_back.sv =====
// Back end: divides, smooths and caps one channel per job, then drives the result register.
// Depends on irral_pkg.
`default_nettype none

module irral_back #(
    parameter int CHANNELS = irral_pkg::DEF_CHANNELS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire irral_pkg::irral_job_t          head_job,
    input  wire irral_pkg::irral_qstat_t        q_stat,
    output logic                                pop,
    input  wire logic [irral_pkg::DIST_W-1:0]   distance_cap,
    input  wire logic [irral_pkg::NUMER_W-1:0]  scale_numerator,
    input  wire logic [irral_pkg::OFFSET_W-1:0] scale_offset,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [irral_pkg::CH_OUT_W-1:0]      m_channel,
    output logic [irral_pkg::DIST_W-1:0]        m_distance,
    output logic                                m_final_of_round
);
    import irral_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    irral_bk_state_t state_reg, state_next;

    logic [DIST_W-1:0]    smooth_reg [CHANNELS];
    logic [CH_IDX_W-1:0]  ch_reg;
    logic                 last_reg;
    logic [NUMER_W-1:0]   quo_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic                 m_valid_reg;
    logic [CH_OUT_W-1:0]  m_channel_reg;
    logic [DIST_W-1:0]    m_distance_reg;
    logic                 m_final_reg;

    logic [DEN_W-1:0]  den_next;
    logic [DEN_W:0]    shifted;
    logic              fits;
    logic [DEN_W:0]    diff;
    logic              div_done;
    logic [DIST_W:0]   total;
    logic [DIST_W:0]   total_m1;
    logic [DIST_W-1:0] dist_next;
    logic              slot_free;
    logic              load_out;

    assign den_next  = {1'b0, head_job.avg} + DEN_W'(scale_offset);
    assign shifted   = {rem_reg, quo_reg[NUMER_W-1]};
    assign fits      = (shifted >= {1'b0, den_reg});
    assign diff      = shifted - {1'b0, den_reg};
    assign div_done  = (cnt_reg == DIV_CNT_W'(NUMER_W - 1));
    assign total     = {1'b0, smooth_reg[ch_reg[CH_W-1:0]]} + {1'b0, quo_reg};
    assign total_m1  = total - 1'b1;
    assign dist_next = (total == '0) ? '0 : total_m1[DIST_W:1];
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = (den_next == '0) ? BK_UPD : BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    state_next = BK_UPD;
                end
            end
            BK_UPD: state_next = BK_OUT;
            BK_OUT: begin
                if (slot_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop      = !q_stat.empty;
            BK_OUT:  load_out = slot_free;
            default: begin
                pop      = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            BK_IDLE: begin
                ch_reg   <= head_job.ch;
                last_reg <= head_job.last;
                den_reg  <= den_next;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                quo_reg  <= (den_next == '0) ? '1 : scale_numerator;
            end
            BK_DIV: begin
                quo_reg <= {quo_reg[NUMER_W-2:0], fits};
                rem_reg <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
            end
            BK_UPD: dist_reg <= dist_next;
            default: begin
                dist_reg <= dist_reg;
            end
        endcase
        if (load_out) begin
            m_channel_reg  <= ch_reg[CH_OUT_W-1:0];
            m_distance_reg <= (dist_reg < distance_cap) ? dist_reg : distance_cap;
            m_final_reg    <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                smooth_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                smooth_reg[ch_reg[CH_W-1:0]] <= dist_reg;
                m_valid_reg                  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_channel        = m_channel_reg;
    assign m_distance       = m_distance_reg;
    assign m_final_of_round = m_final_reg;

endmodule

`default_nettype wire

// ===== hdl/ir_range_average_linearize.sv =====
// Top level of the IR range averaging and linearization block: config registers,
// front end, job queue and back end. Depends on irral_pkg, irral_front, irral_queue, irral_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   samples  | s_valid / s_ready  | s_sample
//   results  | m_valid / m_ready  | m_channel, m_distance, m_final_of_round
//   config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Samples are taken one per cycle while s_ready is high; after the last sample of a
// buffer the front end pushes one average per channel with s_ready low, waiting while
// the queue is full. In the back end each channel passes through a load, the bit-serial
// divider, an update and the load of the output register, which waits while a result
// is held and m_ready is low. A zero divisor skips the divider.
// Reset is synchronous, active low, and clears the sums and smoothed distances at once.
`default_nettype none

module ir_range_average_linearize #(
    parameter int CHANNELS = irral_pkg::DEF_CHANNELS,
    parameter int SAMPLES  = irral_pkg::DEF_SAMPLES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [irral_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [irral_pkg::CH_OUT_W-1:0]       m_channel,
    output logic [irral_pkg::DIST_W-1:0]         m_distance,
    output logic                                 m_final_of_round,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [irral_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [irral_pkg::CFG_DATA_W-1:0] cfg_data
);
    import irral_pkg::*;

    logic [DIST_W-1:0]   distance_cap_reg;
    logic [NUMER_W-1:0]  scale_numerator_reg;
    logic [OFFSET_W-1:0] scale_offset_reg;

    irral_qstat_t q_stat;
    irral_job_t   push_job;
    irral_job_t   head_job;
    logic         push;
    logic         pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            distance_cap_reg    <= RST_DISTANCE_CAP;
            scale_numerator_reg <= RST_SCALE_NUMERATOR;
            scale_offset_reg    <= RST_SCALE_OFFSET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DISTANCE_CAP:    distance_cap_reg    <= cfg_data;
                CFG_SCALE_NUMERATOR: scale_numerator_reg <= cfg_data;
                CFG_SCALE_OFFSET:    scale_offset_reg    <= cfg_data[OFFSET_W-1:0];
                default: begin
                    distance_cap_reg <= distance_cap_reg;
                end
            endcase
        end
    end

    irral_front #(
        .CHANNELS (CHANNELS),
        .SAMPLES  (SAMPLES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    irral_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    irral_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_job         (head_job),
        .q_stat           (q_stat),
        .pop              (pop),
        .distance_cap     (distance_cap_reg),
        .scale_numerator  (scale_numerator_reg),
        .scale_offset     (scale_offset_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_channel        (m_channel),
        .m_distance       (m_distance),
        .m_final_of_round (m_final_of_round)
    );

endmodule

`default_nettype wire
